// ----- sv/trse_pkg.sv -----
// Shared types and constants for the tri-state RF switch encoder.
package trse_pkg;

  typedef logic [1:0] sym_t;

  localparam sym_t SYM_ZERO  = 2'd0;
  localparam sym_t SYM_FLOAT = 2'd1;
  localparam sym_t SYM_ONE   = 2'd2;

  localparam int unsigned WORD_W    = 24;
  localparam int unsigned SYM_IDX_W = 4;
  localparam int unsigned NUM_CHAN  = 5;

  localparam logic [SYM_IDX_W-1:0] NUM_SYMBOLS = 4'd12;

  localparam logic [4:0] SHORT_UNITS = 5'd1;
  localparam logic [4:0] LONG_UNITS  = 5'd3;
  localparam logic [4:0] SYNC_LOW_P1 = 5'd31;
  localparam logic [4:0] SYNC_LOW_P2 = 5'd10;

  localparam logic [1:0] PROTO_2 = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PROTOCOL = 2'd2;

  localparam logic [15:0] PULSE_TICKS_RST   = 16'd350;
  localparam logic [7:0]  REPEAT_COUNT_RST  = 8'd10;
  localparam logic [1:0]  SYNC_PROTOCOL_RST = 2'd1;

  typedef struct packed {
    logic       mode;
    logic [4:0] group_bits;
    logic [2:0] channel;
    logic       switch_on;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic              chan_ok;
  } word_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

// ----- sv/trse_word.sv -----
// Builds the 12-symbol tri-state code word from a start command.
module trse_word (
  input  trse_pkg::item_t item,
  output trse_pkg::word_t word
);
  import trse_pkg::*;

  always_comb begin
    word.code_word = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      word.code_word[2*i +: 2]     = item.group_bits[i] ? SYM_ZERO : SYM_FLOAT;
      word.code_word[2*(i+5) +: 2] =
        (item.channel == 3'(i + 1)) ? SYM_ZERO : SYM_FLOAT;
    end
    word.code_word[21:20] = item.switch_on ? SYM_ZERO  : SYM_FLOAT;
    word.code_word[23:22] = item.switch_on ? SYM_FLOAT : SYM_ZERO;
    word.chan_ok = (item.channel >= 3'd1) && (item.channel <= 3'd5);
  end

endmodule

// ----- sv/trse_seq.sv -----
// Config registers, frame sequencer state and per-beat step logic.
module trse_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  trse_pkg::item_t                 item,
  input  trse_pkg::word_t                 word,
  input  logic                            step,
  output trse_pkg::res_t                  res
);
  import trse_pkg::*;

  logic [15:0] pulse_ticks;
  logic [7:0]  repeat_count;
  logic [1:0]  sync_protocol;

  logic [WORD_W-1:0]    code_word, code_word_next;
  logic [SYM_IDX_W-1:0] symbol_index, symbol_index_next;
  logic                 pulse_half, pulse_half_next;
  logic                 level_phase, level_phase_next;
  logic [4:0]           unit_count, unit_count_next;
  logic [15:0]          tick_count, tick_count_next;
  logic [7:0]           repeats_left, repeats_left_next;
  logic                 active, active_next;

  sym_t        syms [16];
  sym_t        sym;
  logic        in_sync;
  logic        short_high;
  logic [4:0]  part_len;
  logic [15:0] pt;
  logic [16:0] tick_inc;
  logic [5:0]  unit_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks   <= PULSE_TICKS_RST;
      repeat_count  <= REPEAT_COUNT_RST;
      sync_protocol <= SYNC_PROTOCOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_TICKS:   pulse_ticks   <= cfg_data;
        REG_REPEAT_COUNT:  repeat_count  <= cfg_data[7:0];
        REG_SYNC_PROTOCOL: sync_protocol <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      syms[k] = (k < 12) ? code_word[2*(k%12) +: 2] : SYM_ZERO;
    end
    in_sync = (symbol_index >= NUM_SYMBOLS);
    sym     = syms[symbol_index];
    unique case (sym)
      SYM_ZERO: short_high = 1'b1;
      SYM_ONE:  short_high = 1'b0;
      default:  short_high = ~pulse_half;
    endcase
    if (in_sync) begin
      if (!level_phase) part_len = SHORT_UNITS;
      else part_len = (sync_protocol == PROTO_2) ? SYNC_LOW_P2 : SYNC_LOW_P1;
    end else if (!level_phase) begin
      part_len = short_high ? SHORT_UNITS : LONG_UNITS;
    end else begin
      part_len = short_high ? LONG_UNITS : SHORT_UNITS;
    end
    pt       = (pulse_ticks == 16'd0) ? 16'd1 : pulse_ticks;
    tick_inc = {1'b0, tick_count} + 17'd1;
    unit_inc = {1'b0, unit_count} + 6'd1;
  end

  always_comb begin
    code_word_next    = code_word;
    symbol_index_next = symbol_index;
    pulse_half_next   = pulse_half;
    level_phase_next  = level_phase;
    unit_count_next   = unit_count;
    tick_count_next   = tick_count;
    repeats_left_next = repeats_left;
    active_next       = active;
    res               = '0;
    if (item.mode) begin
      if (active || !word.chan_ok) begin
        res.rejected = 1'b1;
      end else begin
        code_word_next    = word.code_word;
        symbol_index_next = '0;
        pulse_half_next   = 1'b0;
        level_phase_next  = 1'b0;
        unit_count_next   = '0;
        tick_count_next   = '0;
        repeats_left_next = repeat_count;
        active_next       = (repeat_count != 8'd0);
      end
      res.pin_level = active_next & ~level_phase_next;
      res.busy_res  = active_next;
    end else if (active) begin
      res.pin_level = ~level_phase;
      res.busy_res  = 1'b1;
      if (tick_inc < {1'b0, pt}) begin
        tick_count_next = tick_inc[15:0];
      end else begin
        tick_count_next = '0;
        if (unit_inc < {1'b0, part_len}) begin
          unit_count_next = unit_inc[4:0];
        end else begin
          unit_count_next = '0;
          if (!level_phase) begin
            level_phase_next = 1'b1;
          end else begin
            level_phase_next = 1'b0;
            if (!in_sync) begin
              if (!pulse_half) begin
                pulse_half_next = 1'b1;
              end else begin
                pulse_half_next   = 1'b0;
                symbol_index_next = symbol_index + 4'd1;
              end
            end else begin
              symbol_index_next = '0;
              pulse_half_next   = 1'b0;
              repeats_left_next = repeats_left - 8'd1;
              active_next       = (repeats_left != 8'd1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_word    <= '0;
      symbol_index <= '0;
      pulse_half   <= 1'b0;
      level_phase  <= 1'b0;
      unit_count   <= '0;
      tick_count   <= '0;
      repeats_left <= '0;
      active       <= 1'b0;
    end else if (step) begin
      code_word    <= code_word_next;
      symbol_index <= symbol_index_next;
      pulse_half   <= pulse_half_next;
      level_phase  <= level_phase_next;
      unit_count   <= unit_count_next;
      tick_count   <= tick_count_next;
      repeats_left <= repeats_left_next;
      active       <= active_next;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    symbol_index <= NUM_SYMBOLS)
    else $error("symbol index past sync");

  a_idle_parked: assert property (@(posedge clk) disable iff (rst)
    !active |-> (symbol_index == '0) && !pulse_half && !level_phase
                && (unit_count == '0) && (tick_count == '0))
    else $error("sequencer not parked while idle");

  a_sync_half: assert property (@(posedge clk) disable iff (rst)
    in_sync |-> !pulse_half)
    else $error("second pulse flagged during sync");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    step && res.rejected |=> $stable(code_word) && $stable(repeats_left))
    else $error("refused command changed the frame");
`endif

endmodule

// ----- sv/tristate_rf_switch_encoder.sv -----
// Top level of the tri-state RF switch encoder: input stage, sequencer, result stage.
//
//  Channel | Handshake            | Payload
//  cmd     | cmd_valid, cmd_stall | mode, group_bits, channel, switch_on
//  res     | res_valid, res_stall | pin_level, busy_res, rejected
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One beat per cycle while res_stall is low; a beat enters the input register when it is taken
// and moves on into the result register on a sequencer step.
// Synchronous active-high reset returns the config and sequencer registers to their defaults and idles.
// A stalled result holds; cmd_stall rises only when both stages are full.
module tristate_rf_switch_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic                            mode,
  input  logic [4:0]                      group_bits,
  input  logic [2:0]                      channel,
  input  logic                            switch_on,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            pin_level,
  output logic                            busy_res,
  output logic                            rejected
);
  import trse_pkg::*;

  item_t s1_item;
  logic  s1_valid;
  logic  s2_load;
  logic  step;
  logic  cmd_fire;
  word_t word;
  res_t  res;

  assign s2_load   = ~res_valid | ~res_stall;
  assign step      = s1_valid & s2_load;
  assign cmd_stall = s1_valid & ~s2_load;
  assign cmd_fire  = cmd_valid & ~cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_fire | (s1_valid & ~step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_item.mode       <= mode;
      s1_item.group_bits <= group_bits;
      s1_item.channel    <= channel;
      s1_item.switch_on  <= switch_on;
    end
  end

  trse_word u_word (
    .item (s1_item),
    .word (word)
  );

  trse_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (s1_item),
    .word      (word),
    .step      (step),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_load) begin
      res_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pin_level <= res.pin_level;
      busy_res  <= res.busy_res;
      rejected  <= res.rejected;
    end
  end

endmodule
